// File: rtl/wmm_pkg.sv
// Shared types and constants for the Winograd matrix multiplier.
// Used by wmm_mac, winograd_matrix_multiply_top and the testbench; depends on nothing.
package wmm_pkg;

  localparam int MAX_DIM_DEFAULT = 8;
  localparam int DATA_W          = 16;
  localparam int SUM_W           = 17;
  localparam int ACC_W           = 32;
  localparam int CFG_W           = 4;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS_FIRST  = 2'd0,
    CFG_INNER_SIZE  = 2'd1,
    CFG_COLS_SECOND = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_ROW,
    PH_COL,
    PH_ENT
  } phase_t;

  // Operand formation for the shared multiplier.
  typedef enum logic [1:0] {
    MODE_A_ONLY,
    MODE_B_ONLY,
    MODE_PAIR_SUM,
    MODE_TAIL
  } mac_mode_t;

  typedef struct packed {
    mac_mode_t mode;
    logic      load_x;
    logic      load_prod;
    logic      acc_init;
    logic      acc_add;
  } mac_ctrl_t;

endpackage

// File: rtl/wmm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module wmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/wmm_mac.sv
// Shared multiply-accumulate unit: operand formation, one 17x17 multiplier,
// a product register and a 32-bit wrapping accumulator. Depends on wmm_pkg.
module wmm_mac
  import wmm_pkg::*;
(
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] a_data,
  input  logic signed [DATA_W-1:0] b_data,
  input  logic signed [ACC_W-1:0]  init_value,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [SUM_W-1:0]   a_ext;
  logic signed [SUM_W-1:0]   b_ext;
  logic signed [SUM_W-1:0]   x_sel;
  logic signed [SUM_W-1:0]   y_sel;
  logic signed [SUM_W-1:0]   x;
  logic signed [2*SUM_W-1:0] full;
  logic signed [ACC_W-1:0]   prod;

  assign a_ext = {a_data[DATA_W-1], a_data};
  assign b_ext = {b_data[DATA_W-1], b_data};

  // In tail mode the first operand comes from the first matrix and the
  // second from the second matrix; both are read at the same address twice.
  always_comb begin
    unique case (ctrl.mode)
      MODE_A_ONLY: begin
        x_sel = a_ext;
        y_sel = a_ext;
      end
      MODE_B_ONLY: begin
        x_sel = b_ext;
        y_sel = b_ext;
      end
      MODE_PAIR_SUM: begin
        x_sel = a_ext + b_ext;
        y_sel = a_ext + b_ext;
      end
      default: begin
        x_sel = a_ext;
        y_sel = b_ext;
      end
    endcase
  end

  assign full = x * y_sel;

  always_ff @(posedge clk) begin
    if (ctrl.load_x) begin
      x <= x_sel;
    end
    if (ctrl.load_prod) begin
      prod <= full[ACC_W-1:0];
    end
    if (ctrl.acc_init) begin
      acc <= init_value;
    end else if (ctrl.acc_add) begin
      acc <= acc + prod;
    end
  end

endmodule

// File: rtl/winograd_matrix_multiply_top.sv
// Winograd inner-product matrix multiplier, top level; depends on wmm_pkg, wmm_ram, wmm_mac.
// A compute beat keeps busy high while every term passes through the single read port
// per matrix and the shared multiplier. Each result is registered from its entry's final
// state. Synchronous reset returns the sequencer to idle and the dimensions to 8.
module winograd_matrix_multiply_top
  import wmm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation,
  input  logic [2:0]              row,
  input  logic [2:0]              col,
  input  logic signed [DATA_W-1:0] value,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [ACC_W-1:0] product,
  output logic                    last
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int K_W    = (MAX_DIM / 2 > 1) ? $clog2(MAX_DIM / 2) : 1;

  state_t state;
  state_t state_next;
  phase_t phase;

  logic [CFG_W-1:0] rows_first;
  logic [CFG_W-1:0] inner_size;
  logic [CFG_W-1:0] cols_second;
  logic [DIM_W-1:0] n_dim;
  logic [DIM_W-1:0] mid_dim;
  logic [DIM_W-1:0] m_dim;
  logic [DIM_W-1:0] half;

  logic [IDX_W-1:0] i_cnt;
  logic [IDX_W-1:0] j_cnt;
  logic [K_W-1:0]   k_cnt;
  logic             tail;

  logic             accept;
  logic             load_ok;
  logic [ADDR_W-1:0] ld_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [IDX_W-1:0] e0;
  logic [IDX_W-1:0] e1;
  logic [IDX_W-1:0] t_idx;
  logic [IDX_W-1:0] a_col;
  logic [IDX_W-1:0] b_row;
  logic             pair_last;
  logic             i_last;
  logic             j_last;
  logic             add_tail;

  logic                     a_we;
  logic                     b_we;
  logic signed [DATA_W-1:0] a_rdata;
  logic signed [DATA_W-1:0] b_rdata;

  logic signed [ACC_W-1:0] row_terms [MAX_DIM];
  logic signed [ACC_W-1:0] col_terms [MAX_DIM];
  logic signed [ACC_W-1:0] init_value;
  logic signed [ACC_W-1:0] acc;
  mac_ctrl_t               mac_ctrl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_first  <= CFG_W'(8);
      inner_size  <= CFG_W'(8);
      cols_second <= CFG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS_FIRST:  rows_first  <= cfg_data;
        CFG_INNER_SIZE:  inner_size  <= cfg_data;
        CFG_COLS_SECOND: cols_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero reads as one, anything above the storage size as the storage size.
  always_comb begin
    if (rows_first == '0) n_dim = DIM_W'(1);
    else if (32'(rows_first) > MAX_DIM) n_dim = DIM_W'(MAX_DIM);
    else n_dim = DIM_W'(rows_first);
    if (inner_size == '0) mid_dim = DIM_W'(1);
    else if (32'(inner_size) > MAX_DIM) mid_dim = DIM_W'(MAX_DIM);
    else mid_dim = DIM_W'(inner_size);
    if (cols_second == '0) m_dim = DIM_W'(1);
    else if (32'(cols_second) > MAX_DIM) m_dim = DIM_W'(MAX_DIM);
    else m_dim = DIM_W'(cols_second);
  end

  assign half = mid_dim >> 1;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign load_ok = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
  assign ld_addr = ADDR_W'(32'(row) * MAX_DIM + 32'(col));
  assign a_we    = accept && (op_t'(operation) == OP_LOAD_A) && load_ok;
  assign b_we    = accept && (op_t'(operation) == OP_LOAD_B) && load_ok;

  // Element indices for the current term.
  assign e0    = IDX_W'({k_cnt, 1'b0});
  assign e1    = e0 | IDX_W'(1);
  assign t_idx = IDX_W'(mid_dim - DIM_W'(1));

  always_comb begin
    if (tail) begin
      a_col = t_idx;
      b_row = t_idx;
    end else begin
      a_col = (state == ST_RD0) ? e0 : e1;
      if (phase == PH_COL) b_row = (state == ST_RD0) ? e0 : e1;
      else b_row = (state == ST_RD0) ? e1 : e0;
    end
  end

  assign a_addr = busy ? ADDR_W'(32'(i_cnt) * MAX_DIM + 32'(a_col)) : ld_addr;
  assign b_addr = busy ? ADDR_W'(32'(b_row) * MAX_DIM + 32'(j_cnt)) : ld_addr;

  wmm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_DIM * MAX_DIM)
  ) u_first_matrix (
    .clk  (clk),
    .we   (a_we),
    .addr (a_addr),
    .wdata(value),
    .rdata(a_rdata)
  );

  wmm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_DIM * MAX_DIM)
  ) u_second_matrix (
    .clk  (clk),
    .we   (b_we),
    .addr (b_addr),
    .wdata(value),
    .rdata(b_rdata)
  );

  assign init_value = (phase == PH_ENT) ?
                      (ACC_W'(0) - row_terms[i_cnt] - col_terms[j_cnt]) : '0;

  wmm_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .init_value(init_value),
    .acc       (acc)
  );

  assign pair_last = ((DIM_W'(k_cnt) + DIM_W'(1)) == half);
  assign i_last    = (i_cnt == IDX_W'(n_dim - DIM_W'(1)));
  assign j_last    = (j_cnt == IDX_W'(m_dim - DIM_W'(1)));
  assign add_tail  = (phase == PH_ENT) && mid_dim[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    mac_ctrl.load_x    = 1'b0;
    mac_ctrl.load_prod = 1'b0;
    mac_ctrl.acc_init  = 1'b0;
    mac_ctrl.acc_add   = 1'b0;
    if (phase == PH_ROW) mac_ctrl.mode = MODE_A_ONLY;
    else if (phase == PH_COL) mac_ctrl.mode = MODE_B_ONLY;
    else if (tail) mac_ctrl.mode = MODE_TAIL;
    else mac_ctrl.mode = MODE_PAIR_SUM;
    unique case (state)
      ST_IDLE: begin
        if (accept && op_t'(operation) == OP_COMPUTE) state_next = ST_INIT;
      end
      ST_INIT: begin
        mac_ctrl.acc_init = 1'b1;
        // With no pairs the factor is zero and only an entry's tail remains.
        if (half == '0 && phase != PH_ENT) state_next = ST_FIN;
        else state_next = ST_RD0;
      end
      ST_RD0: begin
        state_next = ST_RD1;
      end
      ST_RD1: begin
        mac_ctrl.load_x = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        mac_ctrl.load_prod = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_add = 1'b1;
        if (!tail && (!pair_last || add_tail)) state_next = ST_RD0;
        else state_next = ST_FIN;
      end
      ST_FIN: begin
        if (phase == PH_ENT && i_last && j_last) state_next = ST_IDLE;
        else state_next = ST_INIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Loop counters and phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ROW;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
      tail  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && op_t'(operation) == OP_COMPUTE) begin
            phase <= PH_ROW;
            i_cnt <= '0;
            j_cnt <= '0;
          end
        end
        ST_INIT: begin
          k_cnt <= '0;
          tail  <= (half == '0);
        end
        ST_ACC: begin
          if (!tail && !pair_last) k_cnt <= k_cnt + K_W'(1);
          else if (!tail && add_tail) tail <= 1'b1;
        end
        ST_FIN: begin
          if (phase == PH_ROW) begin
            if (i_last) begin
              phase <= PH_COL;
              j_cnt <= '0;
            end else begin
              i_cnt <= i_cnt + IDX_W'(1);
            end
          end else if (phase == PH_COL) begin
            if (j_last) begin
              phase <= PH_ENT;
              i_cnt <= '0;
              j_cnt <= '0;
            end else begin
              j_cnt <= j_cnt + IDX_W'(1);
            end
          end else begin
            if (j_last) begin
              j_cnt <= '0;
              if (!i_last) i_cnt <= i_cnt + IDX_W'(1);
            end else begin
              j_cnt <= j_cnt + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Factor storage; each compute rewrites every factor before it is read.
  always_ff @(posedge clk) begin
    if (state == ST_FIN && phase == PH_ROW) row_terms[i_cnt] <= acc;
    if (state == ST_FIN && phase == PH_COL) col_terms[j_cnt] <= acc;
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FIN) && (phase == PH_ENT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && phase == PH_ENT) begin
      out_row <= 3'(i_cnt);
      out_col <= 3'(j_cnt);
      product <= acc;
      last    <= i_last && j_last;
    end
  end

endmodule

// File: tb/sv/wmm_product_checker.sv
// Checker for the Winograd matrix multiplier: mirrors the element stores and dimensions,
// predicts every result entry of a compute beat and compares the emitted entries in order.
// Depends on wmm_pkg for the operation and register codes and the field widths.
`timescale 1ns / 100ps
module wmm_product_checker
  import wmm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               operation,
  input  logic [2:0]               row,
  input  logic [2:0]               col,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     done,
  input  logic [2:0]               out_row,
  input  logic [2:0]               out_col,
  input  logic signed [ACC_W-1:0]  product,
  input  logic                     last,
  output int                       errors,
  output int                       pending
);
  localparam int DIM = MAX_DIM_DEFAULT;

  typedef struct packed {
    logic [2:0]       pos_row;
    logic [2:0]       pos_col;
    logic [ACC_W-1:0] entry;
    logic             is_last;
  } entry_t;

  logic [DATA_W-1:0] first_store [DIM*DIM];
  logic [DATA_W-1:0] second_store [DIM*DIM];
  logic [ACC_W-1:0]  row_corr [DIM];
  logic [ACC_W-1:0]  col_corr [DIM];
  logic [CFG_W-1:0]  rows_reg, inner_reg, cols_reg;
  entry_t            entry_queue [$];
  int                fail_count = 0;

  function automatic int dim_used(logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return int'(d);
  endfunction

  function automatic logic [ACC_W-1:0] first_at(int r, int c);
    logic [DATA_W-1:0] e;
    e = first_store[r*DIM + c];
    return {{(ACC_W-DATA_W){e[DATA_W-1]}}, e};
  endfunction

  function automatic logic [ACC_W-1:0] second_at(int r, int c);
    logic [DATA_W-1:0] e;
    e = second_store[r*DIM + c];
    return {{(ACC_W-DATA_W){e[DATA_W-1]}}, e};
  endfunction

  // All arithmetic stays 32 bits wide, so every sum and product wraps as the block does.
  task automatic predict_product_matrix();
    int n, mid, m, half;
    logic [ACC_W-1:0] acc;
    entry_t e;
    n = dim_used(rows_reg);
    mid = dim_used(inner_reg);
    m = dim_used(cols_reg);
    half = mid / 2;
    for (int i = 0; i < n; i++) begin
      acc = '0;
      for (int k = 0; k < half; k++) acc += first_at(i, 2*k) * first_at(i, 2*k + 1);
      row_corr[i] = acc;
    end
    for (int j = 0; j < m; j++) begin
      acc = '0;
      for (int k = 0; k < half; k++) acc += second_at(2*k, j) * second_at(2*k + 1, j);
      col_corr[j] = acc;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < m; j++) begin
        acc = '0 - row_corr[i] - col_corr[j];
        for (int k = 0; k < half; k++) begin
          acc += (first_at(i, 2*k) + second_at(2*k + 1, j)) *
                 (first_at(i, 2*k + 1) + second_at(2*k, j));
        end
        if (mid % 2) acc += first_at(i, mid - 1) * second_at(mid - 1, j);
        e.pos_row = 3'(i);
        e.pos_col = 3'(j);
        e.entry = acc;
        e.is_last = (i == n - 1) && (j == m - 1);
        entry_queue.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin
    entry_t exp_e;
    bit bad;
    if (rst) begin
      rows_reg = CFG_W'(DIM);
      inner_reg = CFG_W'(DIM);
      cols_reg = CFG_W'(DIM);
      for (int i = 0; i < DIM; i++) begin
        row_corr[i] = '0;
        col_corr[i] = '0;
      end
    end else begin
      if (done === 1'b1) begin
        if (entry_queue.size() == 0) begin
          $error("unexpected result entry: out_row %0d out_col %0d product %0d",
                 out_row, out_col, product);
          fail_count++;
        end else begin
          exp_e = entry_queue.pop_front();
          bad = 0;
          if (out_row !== exp_e.pos_row) begin
            $error("out_row: expected %0d, actual %0d", exp_e.pos_row, out_row);
            bad = 1;
          end
          if (out_col !== exp_e.pos_col) begin
            $error("out_col: expected %0d, actual %0d", exp_e.pos_col, out_col);
            bad = 1;
          end
          if (product !== exp_e.entry) begin
            $error("product: expected %0d, actual %0d", $signed(exp_e.entry), product);
            bad = 1;
          end
          if (last !== exp_e.is_last) begin
            $error("last: expected %0d, actual %0d", exp_e.is_last, last);
            bad = 1;
          end
          if (bad) fail_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROWS_FIRST:  rows_reg = cfg_data;
          CFG_INNER_SIZE:  inner_reg = cfg_data;
          CFG_COLS_SECOND: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (op_t'(operation))
          OP_LOAD_A:  first_store[int'(row)*DIM + int'(col)] = value;
          OP_LOAD_B:  second_store[int'(row)*DIM + int'(col)] = value;
          OP_COMPUTE: predict_product_matrix();
          default: ;
        endcase
      end
    end
    errors <= fail_count;
    pending <= entry_queue.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for winograd_matrix_multiply_top: clock, reset, load and compute beats,
// dimension register writes and the verdict. Depends on wmm_pkg, wmm_product_checker and the DUT.
`timescale 1ns / 100ps
module tb_top;
  import wmm_pkg::*;

  localparam int DIM         = MAX_DIM_DEFAULT;
  localparam int ITEM_TARGET = 470;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               operation = '0;
  logic [2:0]               row = '0;
  logic [2:0]               col = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     cfg_we = 1'b0;
  logic [1:0]               cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     done;
  logic [2:0]               out_row;
  logic [2:0]               out_col;
  logic signed [ACC_W-1:0]  product;
  logic                     last;
  int                       errors;
  int                       pending;

  int cycle_count = 0;
  int item_count = 0;
  bit gaps_on = 1;
  int rows_used = DIM;
  int inner_used = DIM;
  int cols_used = DIM;
  bit first_written [DIM*DIM];
  bit second_written [DIM*DIM];

  always #2 clk = ~clk;

  winograd_matrix_multiply_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .row(row), .col(col), .value(value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .out_row(out_row), .out_col(out_col), .product(product), .last(last)
  );

  wmm_product_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .row(row), .col(col), .value(value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .out_row(out_row), .out_col(out_col), .product(product), .last(last),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[winograd_matrix_multiply_top] ERROR");
      $finish;
    end
  end

  function automatic int dim_of(logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return int'(d);
  endfunction

  function automatic logic [DATA_W-1:0] element_value();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Start is held high from one beat to the next unless a random gap is taken.
  task automatic drive_beat(op_t op, logic [2:0] r, logic [2:0] c, logic [DATA_W-1:0] v);
    while (gaps_on && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    row <= r;
    col <= c;
    value <= v;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD_A) first_written[int'(r)*DIM + int'(c)] = 1;
    if (op == OP_LOAD_B) second_written[int'(r)*DIM + int'(c)] = 1;
    if (op != OP_NONE) item_count++;
  endtask

  // Waits until the block is idle and every expected entry has come out.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] i,
                            logic [CFG_W-1:0] c, bit touch_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROWS_FIRST;
    cfg_data <= r;
    @(posedge clk);
    cfg_index <= CFG_INNER_SIZE;
    cfg_data <= i;
    @(posedge clk);
    cfg_index <= CFG_COLS_SECOND;
    cfg_data <= c;
    @(posedge clk);
    if (touch_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data <= CFG_W'($urandom_range(15));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    rows_used = dim_of(r);
    inner_used = dim_of(i);
    cols_used = dim_of(c);
  endtask

  // Every element that the compute will read must have been loaded first.
  task automatic run_compute();
    for (int i = 0; i < rows_used; i++)
      for (int k = 0; k < inner_used; k++)
        if (!first_written[i*DIM + k]) drive_beat(OP_LOAD_A, 3'(i), 3'(k), element_value());
    for (int k = 0; k < inner_used; k++)
      for (int j = 0; j < cols_used; j++)
        if (!second_written[k*DIM + j]) drive_beat(OP_LOAD_B, 3'(k), 3'(j), element_value());
    drive_beat(OP_COMPUTE, 3'($urandom_range(7)), 3'($urandom_range(7)), DATA_W'($urandom));
  endtask

  function automatic logic [CFG_W-1:0] random_dim();
    if ($urandom_range(9) < 7) return CFG_W'($urandom_range(1, 4));
    return CFG_W'($urandom_range(15));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero rows is treated as one; a one-term inner size takes only the tail product.
    write_dims(4'd0, 4'd1, 4'd1, 1'b1);
    drive_beat(OP_LOAD_A, 3'd0, 3'd0, 16'h8000);
    drive_beat(OP_LOAD_B, 3'd0, 3'd0, 16'h8000);
    drive_beat(OP_NONE, 3'd7, 3'd7, 16'hffff);
    drive_beat(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
    settle();

    write_dims(4'd2, 4'd2, 4'd2, 1'b0);
    drive_beat(OP_LOAD_A, 3'd0, 3'd1, 16'h7fff);
    drive_beat(OP_LOAD_A, 3'd1, 3'd0, 16'h7fff);
    drive_beat(OP_LOAD_A, 3'd1, 3'd1, 16'h8000);
    drive_beat(OP_LOAD_B, 3'd1, 3'd0, 16'h7fff);
    drive_beat(OP_LOAD_B, 3'd0, 3'd1, 16'hffff);
    drive_beat(OP_LOAD_B, 3'd1, 3'd1, 16'h8000);
    drive_beat(OP_LOAD_A, 3'd7, 3'd7, 16'h7fff);
    drive_beat(OP_LOAD_B, 3'd7, 3'd7, 16'h8000);
    drive_beat(OP_COMPUTE, 3'd7, 3'd7, 16'hffff);
    settle();

    // Oversized values saturate to the full eight by eight by eight product.
    write_dims(4'd15, 4'd15, 4'd15, 1'b0);
    run_compute();
    settle();
    write_dims(4'd8, 4'd8, 4'd8, 1'b1);
    run_compute();

    while (item_count < ITEM_TARGET) begin
      if ($urandom_range(3) != 0) begin
        settle();
        write_dims(random_dim(), random_dim(), random_dim(), $urandom_range(4) == 0);
      end
      gaps_on = !(item_count >= 250 && item_count < 350);
      repeat ($urandom_range(10)) begin
        if ($urandom_range(9) == 0)
          drive_beat(OP_NONE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                     DATA_W'($urandom));
        else
          drive_beat(op_t'($urandom_range(1)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                     element_value());
      end
      run_compute();
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[winograd_matrix_multiply_top] OK");
    end else begin
      $display("[winograd_matrix_multiply_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wmm_pkg.sv
rtl/wmm_ram.sv
rtl/wmm_mac.sv
rtl/winograd_matrix_multiply_top.sv
tb/sv/wmm_product_checker.sv
tb/sv/tb_top.sv
